[rtl/core/tfbc_pkg.sv]
// Package for the two-round Feistel byte cipher.
// Holds the permutation and S-box tables, the round function, the key schedule
// and the record that the round cells pass along. It depends on nothing else.
`default_nettype none

package tfbc_pkg;

    localparam int NUM_CELLS = 2;

    // Permutation tables: output bit i takes input bit (entry - 1).
    localparam logic [3:0] EP_TAB  [8]  = '{4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
    localparam logic [3:0] P4_TAB  [4]  = '{4'd2, 4'd4, 4'd3, 4'd1};
    localparam logic [3:0] P10_TAB [10] = '{4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                            4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
    localparam logic [3:0] P8_TAB  [8]  = '{4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
    localparam logic [3:0] IP_TAB  [8]  = '{4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
    localparam logic [3:0] IPI_TAB [8]  = '{4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};

    // S-boxes, indexed [column][row].
    localparam logic [1:0] S0_TAB [4][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                             '{2'd3, 2'd2, 2'd1, 2'd0},
                                             '{2'd0, 2'd2, 2'd1, 2'd3},
                                             '{2'd3, 2'd1, 2'd3, 2'd2}};
    localparam logic [1:0] S1_TAB [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                             '{2'd2, 2'd0, 2'd1, 2'd3},
                                             '{2'd3, 2'd0, 2'd1, 2'd0},
                                             '{2'd2, 2'd1, 2'd0, 2'd3}};

    // Work record handed from one round cell to the next.
    typedef struct packed {
        logic [3:0] l;
        logic [3:0] h;
        logic [7:0] k_now;
        logic [7:0] k_next;
    } t_cell;

    typedef struct packed {
        logic [7:0] k1;
        logic [7:0] k2;
    } t_subkeys;

    function automatic logic [7:0] perm_ip(input logic [7:0] din);
        logic [7:0] dout;
        for (int i = 0; i < 8; i++) begin
            dout[i] = din[3'(IP_TAB[i] - 4'd1)];
        end
        return dout;
    endfunction

    function automatic logic [7:0] perm_ipi(input logic [7:0] din);
        logic [7:0] dout;
        for (int i = 0; i < 8; i++) begin
            dout[i] = din[3'(IPI_TAB[i] - 4'd1)];
        end
        return dout;
    endfunction

    function automatic logic [1:0] sbox0(input logic [3:0] x);
        return S0_TAB[{x[2], x[1]}][{x[3], x[0]}];
    endfunction

    function automatic logic [1:0] sbox1(input logic [3:0] x);
        return S1_TAB[{x[2], x[1]}][{x[3], x[0]}];
    endfunction

    // Round function: expand, mix in the subkey, substitute, permute.
    function automatic logic [3:0] round_f(input logic [3:0] nib, input logic [7:0] key);
        logic [7:0] e;
        logic [3:0] c;
        logic [3:0] dout;
        for (int i = 0; i < 8; i++) begin
            e[i] = nib[2'(EP_TAB[i] - 4'd1)];
        end
        e = e ^ key;
        c = {sbox1(e[7:4]), sbox0(e[3:0])};
        for (int i = 0; i < 4; i++) begin
            dout[i] = c[2'(P4_TAB[i] - 4'd1)];
        end
        return dout;
    endfunction

    function automatic logic [4:0] rot5(input logic [4:0] v);
        return {v[3:0], v[4]};
    endfunction

    function automatic logic [7:0] perm_p8(input logic [9:0] din);
        logic [7:0] dout;
        for (int i = 0; i < 8; i++) begin
            dout[i] = din[P8_TAB[i] - 4'd1];
        end
        return dout;
    endfunction

    function automatic t_subkeys key_schedule(input logic [9:0] key);
        logic [9:0] pk;
        logic [4:0] lo;
        logic [4:0] hi;
        t_subkeys   ks;
        for (int i = 0; i < 10; i++) begin
            pk[i] = key[P10_TAB[i] - 4'd1];
        end
        lo    = rot5(pk[4:0]);
        hi    = rot5(pk[9:5]);
        ks.k1 = perm_p8({hi, lo});
        lo    = rot5(lo);
        hi    = rot5(hi);
        ks.k2 = perm_p8({hi, lo});
        return ks;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tfbc_round_cell.sv]
// One Feistel round cell: a register stage with its own valid bit.
// Applies one round and the half swap, then hands the record to its neighbor.
// Depends on tfbc_pkg.
`default_nettype none

module tfbc_round_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  tfbc_pkg::t_cell   i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output tfbc_pkg::t_cell   o_data
);
    import tfbc_pkg::*;

    logic  r_vld;
    t_cell r_data;
    t_cell n_data;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    // The round result lands in the high half's place after the swap, so the
    // old high half becomes the new low half. The key slots rotate so the
    // next cell sees the second subkey.
    always_comb begin
        n_data.l      = i_data.h;
        n_data.h      = i_data.l ^ round_f(i_data.h, i_data.k_now);
        n_data.k_now  = i_data.k_next;
        n_data.k_next = i_data.k_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/toy_feistel_byte_cipher.sv]
// Each accepted input beat passes two round cells, then the output register.
// Throughput: one beat per cycle; each cell and the output register stall on
// their own, so gaps fill while the output waits.
// Reset (synchronous, active low) empties all stages and clears the key to 0.
// Depends on tfbc_pkg and tfbc_round_cell.
`default_nettype none

module toy_feistel_byte_cipher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [9:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_in
    input  wire         s_axis_tuser,   // [0] cmd: 0 encrypt, 1 decrypt
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] data_out
);
    import tfbc_pkg::*;

    // Subkeys are derived once, when the key is written.
    t_subkeys r_keys;

    logic       c_vld   [NUM_CELLS+1];
    logic       c_rdy   [NUM_CELLS+1];
    t_cell      c_data  [NUM_CELLS+1];

    logic       r_out_vld;
    logic [7:0] r_out_data;
    logic       out_rdy;
    logic [7:0] ip_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (i_cfg_we) begin
            r_keys <= key_schedule(i_cfg_wdata);
        end
    end

    assign ip_byte        = perm_ip(s_axis_tdata);
    assign c_vld[0]       = s_axis_tvalid;
    assign s_axis_tready  = c_rdy[0];
    assign c_data[0].l    = ip_byte[3:0];
    assign c_data[0].h    = ip_byte[7:4];
    assign c_data[0].k_now  = s_axis_tuser ? r_keys.k2 : r_keys.k1;
    assign c_data[0].k_next = s_axis_tuser ? r_keys.k1 : r_keys.k2;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        tfbc_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_vld[g]),
            .o_ready (c_rdy[g]),
            .i_data  (c_data[g]),
            .o_valid (c_vld[g+1]),
            .i_ready (c_rdy[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    assign out_rdy          = !r_out_vld || m_axis_tready;
    assign c_rdy[NUM_CELLS] = out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= c_vld[NUM_CELLS];
        end
    end

    // The last cell's swap is undone here: its low half is the final high half.
    always_ff @(posedge i_clk) begin
        if (out_rdy && c_vld[NUM_CELLS]) begin
            r_out_data <= perm_ipi({c_data[NUM_CELLS].l, c_data[NUM_CELLS].h});
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> s_axis_tready)
        else $error("input not ready although the output stage is empty");

    a_last_cell_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_vld[NUM_CELLS] && out_rdy |=> m_axis_tvalid)
        else $error("beat from the last cell was lost");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !c_vld[NUM_CELLS] |=> !m_axis_tvalid)
        else $error("output beat repeated after it was taken");

endmodule

`default_nettype wire
